// ===== rtl/pcne_pkg.sv =====
package pcne_pkg;

  localparam int MAX_CELLS_PER_AXIS = 64;
  localparam int POS_W = 32;
  localparam int LEN_W = 31;
  localparam int CFG_CELL_W = 7;
  localparam int IDX_W = 18;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_SIDE_X    = 3'd0,
    REG_SIDE_Y    = 3'd1,
    REG_SIDE_Z    = 3'd2,
    REG_CELL_SIZE = 3'd3,
    REG_CELLS_X   = 3'd4,
    REG_CELLS_Y   = 3'd5,
    REG_CELLS_Z   = 3'd6,
    REG_NONE      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    OFS_DEC  = 2'd0,
    OFS_HOLD = 2'd1,
    OFS_INC  = 2'd2
  } ofs_t;

endpackage

// ===== rtl/pcne_div.sv =====
module pcne_div #(
  parameter int NW = 32,
  parameter int DW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] sb_i,
  output logic          v_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] sb_o
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [SW-1:0] sb_r  [NW];
  logic [NW-1:0] v_r;

  logic [DW-1:0] prem [NW];
  logic [NW-1:0] pnum [NW];
  logic [NW-1:0] pquo [NW];
  logic [SW-1:0] psb  [NW];
  logic [NW-1:0] pv;

  logic [DW-1:0] rem_nxt [NW];
  logic [NW-1:0] num_nxt [NW];
  logic [NW-1:0] quo_nxt [NW];

  for (genvar s = 0; s < NW; s++) begin : g_prev
    if (s == 0) begin : g_first
      assign prem[s] = '0;
      assign pnum[s] = num_i;
      assign pquo[s] = '0;
      assign psb[s]  = sb_i;
      assign pv[s]   = v_i;
    end else begin : g_rest
      assign prem[s] = rem_r[s-1];
      assign pnum[s] = num_r[s-1];
      assign pquo[s] = quo_r[s-1];
      assign psb[s]  = sb_r[s-1];
      assign pv[s]   = v_r[s-1];
    end
  end

  always_comb begin
    logic [DW:0] trial;
    logic        qb;
    for (int s = 0; s < NW; s++) begin
      trial = {prem[s], pnum[s][NW-1]};
      qb = (trial >= {1'b0, den_i});
      if (qb) begin
        rem_nxt[s] = DW'(trial - {1'b0, den_i});
      end else begin
        rem_nxt[s] = trial[DW-1:0];
      end
      num_nxt[s] = {pnum[s][NW-2:0], 1'b0};
      quo_nxt[s] = {pquo[s][NW-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NW; s++) begin
        rem_r[s] <= rem_nxt[s];
        num_r[s] <= num_nxt[s];
        quo_r[s] <= quo_nxt[s];
        sb_r[s]  <= psb[s];
      end
    end
  end

  assign v_o   = v_r[NW-1];
  assign quo_o = quo_r[NW-1];
  assign rem_o = rem_r[NW-1];
  assign sb_o  = sb_r[NW-1];

endmodule

// ===== rtl/pcne_axis.sv =====
module pcne_axis #(
  parameter int CW = 7
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            v_i,
  input  logic [pcne_pkg::POS_W-1:0]      pos_i,
  input  logic [pcne_pkg::LEN_W-1:0]      side_i,
  input  logic [pcne_pkg::LEN_W-1:0]      csz_i,
  input  logic [CW-1:0]                   n_i,
  output logic                            v_o,
  output logic [CW-1:0]                   h_o
);

  localparam int PW = pcne_pkg::POS_W;
  localparam int LW = pcne_pkg::LEN_W;

  logic          v0_r;
  logic [PW-1:0] mag0_r;
  logic          neg0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r <= pos_i[PW-1];
      mag0_r <= pos_i[PW-1] ? PW'(~pos_i + 1'b1) : pos_i;
    end
  end

  logic          v1;
  logic [PW-1:0] quo1;
  logic [LW-1:0] rem1;
  logic          neg1;

  pcne_div #(.NW(PW), .DW(LW), .SW(1)) u_div_side (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(v0_r), .num_i(mag0_r), .den_i(side_i),
    .sb_i(neg0_r), .v_o(v1), .quo_o(quo1), .rem_o(rem1), .sb_o(neg1)
  );

  logic          vf_r;
  logic [LW-1:0] w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_i == '0) begin
        w_r <= '0;
      end else if (neg1 && (rem1 != '0)) begin
        w_r <= side_i - rem1;
      end else begin
        w_r <= rem1;
      end
    end
  end

  logic          v2;
  logic [LW-1:0] quo2;
  logic [LW-1:0] rem2;
  logic          sb2;

  pcne_div #(.NW(LW), .DW(LW), .SW(1)) u_div_cell (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(vf_r), .num_i(w_r), .den_i(csz_i),
    .sb_i(1'b0), .v_o(v2), .quo_o(quo2), .rem_o(rem2), .sb_o(sb2)
  );

  logic [LW-1:0] quo3;
  logic [CW-1:0] rem3;
  logic          sb3;

  pcne_div #(.NW(LW), .DW(CW), .SW(1)) u_div_cnt (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(v2), .num_i(quo2), .den_i(n_i),
    .sb_i(1'b0), .v_o(v_o), .quo_o(quo3), .rem_o(rem3), .sb_o(sb3)
  );

  assign h_o = (csz_i == '0) ? '0 : rem3;

endmodule

// ===== rtl/pcne_enum.sv =====
module pcne_enum #(
  parameter int CW = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       v_i,
  input  logic [CW-1:0]              hx_i,
  input  logic [CW-1:0]              hy_i,
  input  logic [CW-1:0]              hz_i,
  input  logic [CW-1:0]              nx_i,
  input  logic [CW-1:0]              ny_i,
  input  logic [CW-1:0]              nz_i,
  input  logic [2*CW-1:0]            nxny_i,
  input  logic [pcne_pkg::IDX_W-1:0] home_i,
  output logic                       en_o,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [39:0]                out_tdata,
  output logic                       out_tlast
);

  localparam int IW = pcne_pkg::IDX_W;
  localparam int PW = (3 * CW + 2 > IW) ? 3 * CW + 2 : IW;

  logic                 busy_r;
  logic [CW-1:0]        hx_r, hy_r, hz_r;
  logic [2*CW-1:0]      nxny_r;
  logic [IW-1:0]        home_r;
  pcne_pkg::ofs_t       oi_r, oj_r, ok_r;
  pcne_pkg::ofs_t       oi_nxt, oj_nxt, ok_nxt;
  pcne_pkg::ofs_t       lox, loy, loz;

  logic          emit, last_now;
  logic [CW-1:0] cx, cy, cz;
  logic [PW-1:0] nb;

  logic          out_valid_r;
  logic [IW-1:0] out_home_r, out_nb_r;
  logic          out_last_r;

  function automatic logic [CW-1:0] wrap(input logic [CW-1:0] h, input pcne_pkg::ofs_t o,
                                         input logic [CW-1:0] n);
    logic [CW:0] hp;
    hp = {1'b0, h} + 1'b1;
    case (o)
      pcne_pkg::OFS_DEC:  wrap = (h == '0) ? CW'(n - 1'b1) : CW'(h - 1'b1);
      pcne_pkg::OFS_INC:  wrap = (hp == {1'b0, n}) ? '0 : hp[CW-1:0];
      default:            wrap = h;
    endcase
  endfunction

  assign lox = (nx_i > CW'(2)) ? pcne_pkg::OFS_DEC : pcne_pkg::OFS_HOLD;
  assign loy = (ny_i > CW'(2)) ? pcne_pkg::OFS_DEC : pcne_pkg::OFS_HOLD;
  assign loz = (nz_i > CW'(2)) ? pcne_pkg::OFS_DEC : pcne_pkg::OFS_HOLD;

  assign emit     = busy_r && (!out_valid_r || out_tready);
  assign last_now = (oi_r == pcne_pkg::OFS_INC) && (oj_r == pcne_pkg::OFS_INC)
                    && (ok_r == pcne_pkg::OFS_INC);
  assign en_o     = !busy_r || (emit && last_now);

  assign cx = wrap(hx_r, oi_r, nx_i);
  assign cy = wrap(hy_r, oj_r, ny_i);
  assign cz = wrap(hz_r, ok_r, nz_i);
  assign nb = PW'(cx) + PW'(cy) * PW'(nx_i) + PW'(cz) * PW'(nxny_r);

  always_comb begin
    oi_nxt = oi_r;
    oj_nxt = oj_r;
    ok_nxt = ok_r;
    if (en_o) begin
      oi_nxt = lox;
      oj_nxt = loy;
      ok_nxt = loz;
    end else if (emit) begin
      if (ok_r == pcne_pkg::OFS_INC) begin
        ok_nxt = loz;
        if (oj_r == pcne_pkg::OFS_INC) begin
          oj_nxt = loy;
          oi_nxt = pcne_pkg::ofs_t'(oi_r + 2'd1);
        end else begin
          oj_nxt = pcne_pkg::ofs_t'(oj_r + 2'd1);
        end
      end else begin
        ok_nxt = pcne_pkg::ofs_t'(ok_r + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      oi_r        <= pcne_pkg::OFS_HOLD;
      oj_r        <= pcne_pkg::OFS_HOLD;
      ok_r        <= pcne_pkg::OFS_HOLD;
    end else begin
      if (en_o) begin
        busy_r <= v_i;
      end
      oi_r <= oi_nxt;
      oj_r <= oj_nxt;
      ok_r <= ok_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      hx_r   <= hx_i;
      hy_r   <= hy_i;
      hz_r   <= hz_i;
      nxny_r <= nxny_i;
      home_r <= home_i;
    end
    if (emit) begin
      out_home_r <= home_r;
      out_nb_r   <= nb[IW-1:0];
      out_last_r <= last_now;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_nb_r, out_home_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/periodic_cell_neighbor_enum.sv =====
// Throughput: one result per cycle while out_tready does not stall the output; a
// position yields 8 to 27 results, one per neighbor cell. The rate is set by the
// single result register feeding the output channel. The divider pipelines
// accept a new position in the cycle the previous one emits its last neighbor.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
module periodic_cell_neighbor_enum #(
  parameter int MAX_CELLS_PER_AXIS = pcne_pkg::MAX_CELLS_PER_AXIS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [95:0]                 in_tdata,   // pos_x, pos_y, pos_z
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,  // home_cell, neighbor_cell, pad
  output logic                        out_tlast,  // last
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pcne_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [pcne_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [pcne_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CW = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int LW = pcne_pkg::LEN_W;
  localparam int KW = pcne_pkg::CFG_CELL_W;
  localparam int IW = pcne_pkg::IDX_W;
  localparam int DW = pcne_pkg::DATA_W;
  localparam int PW = (3 * CW + 2 > IW) ? 3 * CW + 2 : IW;

  logic [LW-1:0] side_x_r, side_y_r, side_z_r, cell_size_r;
  logic [KW-1:0] cells_x_r, cells_y_r, cells_z_r;
  pcne_pkg::reg_idx_t ridx;
  logic          wr;

  assign ridx       = pcne_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_x_r    <= LW'(65536);
      side_y_r    <= LW'(65536);
      side_z_r    <= LW'(65536);
      cell_size_r <= LW'(65536);
      cells_x_r   <= KW'(1);
      cells_y_r   <= KW'(1);
      cells_z_r   <= KW'(1);
    end else if (wr) begin
      case (ridx)
        pcne_pkg::REG_SIDE_X:    side_x_r    <= cfg_pwdata[LW-1:0];
        pcne_pkg::REG_SIDE_Y:    side_y_r    <= cfg_pwdata[LW-1:0];
        pcne_pkg::REG_SIDE_Z:    side_z_r    <= cfg_pwdata[LW-1:0];
        pcne_pkg::REG_CELL_SIZE: cell_size_r <= cfg_pwdata[LW-1:0];
        pcne_pkg::REG_CELLS_X:   cells_x_r   <= cfg_pwdata[KW-1:0];
        pcne_pkg::REG_CELLS_Y:   cells_y_r   <= cfg_pwdata[KW-1:0];
        pcne_pkg::REG_CELLS_Z:   cells_z_r   <= cfg_pwdata[KW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      pcne_pkg::REG_SIDE_X:    cfg_prdata = DW'(side_x_r);
      pcne_pkg::REG_SIDE_Y:    cfg_prdata = DW'(side_y_r);
      pcne_pkg::REG_SIDE_Z:    cfg_prdata = DW'(side_z_r);
      pcne_pkg::REG_CELL_SIZE: cfg_prdata = DW'(cell_size_r);
      pcne_pkg::REG_CELLS_X:   cfg_prdata = DW'(cells_x_r);
      pcne_pkg::REG_CELLS_Y:   cfg_prdata = DW'(cells_y_r);
      pcne_pkg::REG_CELLS_Z:   cfg_prdata = DW'(cells_z_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  function automatic logic [CW-1:0] clamp(input logic [KW-1:0] c);
    if (c == '0) begin
      clamp = CW'(1);
    end else if (32'(c) > 32'(MAX_CELLS_PER_AXIS)) begin
      clamp = CW'(MAX_CELLS_PER_AXIS);
    end else begin
      clamp = CW'(c);
    end
  endfunction

  logic [CW-1:0] nx, ny, nz;
  assign nx = clamp(cells_x_r);
  assign ny = clamp(cells_y_r);
  assign nz = clamp(cells_z_r);

  logic          en;
  logic          vx, vy, vz;
  logic [CW-1:0] hx, hy, hz;

  assign in_tready = en;

  pcne_axis #(.CW(CW)) u_ax_x (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(in_tvalid), .pos_i(in_tdata[31:0]),
    .side_i(side_x_r), .csz_i(cell_size_r), .n_i(nx), .v_o(vx), .h_o(hx)
  );
  pcne_axis #(.CW(CW)) u_ax_y (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(in_tvalid), .pos_i(in_tdata[63:32]),
    .side_i(side_y_r), .csz_i(cell_size_r), .n_i(ny), .v_o(vy), .h_o(hy)
  );
  pcne_axis #(.CW(CW)) u_ax_z (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(in_tvalid), .pos_i(in_tdata[95:64]),
    .side_i(side_z_r), .csz_i(cell_size_r), .n_i(nz), .v_o(vz), .h_o(hz)
  );

  logic            vp_r, vh_r;
  logic [CW-1:0]   hxp_r, hyp_r, hzp_r, hxh_r, hyh_r, hzh_r;
  logic [2*CW-1:0] nxny_p_r, nxny_h_r;
  logic [IW-1:0]   home_h_r;
  logic [PW-1:0]   home_sum;

  assign home_sum = PW'(hxp_r) + PW'(hyp_r) * PW'(nx) + PW'(hzp_r) * PW'(nxny_p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vh_r <= 1'b0;
    end else if (en) begin
      vp_r <= vx && vy && vz;
      vh_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hxp_r    <= hx;
      hyp_r    <= hy;
      hzp_r    <= hz;
      nxny_p_r <= (2*CW)'(nx) * (2*CW)'(ny);
      hxh_r    <= hxp_r;
      hyh_r    <= hyp_r;
      hzh_r    <= hzp_r;
      nxny_h_r <= nxny_p_r;
      home_h_r <= home_sum[IW-1:0];
    end
  end

  pcne_enum #(.CW(CW)) u_enum (
    .clk(clk), .rst_n(rst_n), .v_i(vh_r), .hx_i(hxh_r), .hy_i(hyh_r), .hz_i(hzh_r),
    .nx_i(nx), .ny_i(ny), .nz_i(nz), .nxny_i(nxny_h_r), .home_i(home_h_r),
    .en_o(en), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

endmodule

// ===== rtl/pcne_checker.sv =====
module pcne_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port not ready");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind periodic_cell_neighbor_enum pcne_checker u_pcne_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast), .cfg_pready(cfg_pready)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [pcne_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [pcne_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [pcne_pkg::DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  typedef struct packed {
    logic [pcne_pkg::IDX_W-1:0] home;
    logic [pcne_pkg::IDX_W-1:0] nbr;
    logic last;
  } cell_res_t;

  cell_res_t cells_due[$];
  int errors = 0;
  bit sink_idle = 1'b1;
  bit hold_sink = 1'b0;
  bit quiet = 1'b0;

  logic [30:0] box_x, box_y, box_z, edge_len;
  logic [6:0] cnt_x, cnt_y, cnt_z;

  periodic_cell_neighbor_enum dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic int unsigned clamp_count(logic [6:0] n);
    if (n == 0) return 1;
    if (n > pcne_pkg::MAX_CELLS_PER_AXIS) return pcne_pkg::MAX_CELLS_PER_AXIS;
    return 32'(n);
  endfunction

  function automatic int unsigned home_on_axis(logic [31:0] raw, logic [30:0] len,
                                               int unsigned n);
    longint p;
    longint w;
    p = longint'($signed(raw));
    if (len == 0) w = 0;
    else begin
      w = p % longint'(len);
      if (w < 0) w += longint'(len);
    end
    if (edge_len == 0) return 0;
    return int'((w / longint'(edge_len)) % n);
  endfunction

  task automatic predict_cells(logic [95:0] pos);
    int unsigned nx, ny, nz, hx, hy, hz, cx, cy, cz;
    int lx, ly, lz;
    logic [pcne_pkg::IDX_W-1:0] home;
    cell_res_t r;
    nx = clamp_count(cnt_x);
    ny = clamp_count(cnt_y);
    nz = clamp_count(cnt_z);
    hx = home_on_axis(pos[31:0], box_x, nx);
    hy = home_on_axis(pos[63:32], box_y, ny);
    hz = home_on_axis(pos[95:64], box_z, nz);
    lx = nx > 2 ? -1 : 0;
    ly = ny > 2 ? -1 : 0;
    lz = nz > 2 ? -1 : 0;
    home = (pcne_pkg::IDX_W)'(hx + hy * nx + hz * nx * ny);
    for (int i = lx; i <= 1; i++) begin
      cx = (hx + i + nx) % nx;
      for (int j = ly; j <= 1; j++) begin
        cy = (hy + j + ny) % ny;
        for (int k = lz; k <= 1; k++) begin
          cz = (hz + k + nz) % nz;
          r.home = home;
          r.nbr = (pcne_pkg::IDX_W)'(cx + cy * nx + cz * nx * ny);
          r.last = (i == 1 && j == 1 && k == 1);
          cells_due = {cells_due, r};
        end
      end
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(pcne_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= (pcne_pkg::ADDR_W)'(4 * idx);
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      pcne_pkg::REG_SIDE_X: box_x = val[30:0];
      pcne_pkg::REG_SIDE_Y: box_y = val[30:0];
      pcne_pkg::REG_SIDE_Z: box_z = val[30:0];
      pcne_pkg::REG_CELL_SIZE: edge_len = val[30:0];
      pcne_pkg::REG_CELLS_X: cnt_x = val[6:0];
      pcne_pkg::REG_CELLS_Y: cnt_y = val[6:0];
      pcne_pkg::REG_CELLS_Z: cnt_z = val[6:0];
      default: ;
    endcase
  endtask

  task automatic send_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!quiet && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    predict_cells({z, y, x});
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (cells_due.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic configure(logic [30:0] sx, logic [30:0] sy, logic [30:0] sz,
                           logic [30:0] cs, logic [6:0] nx, logic [6:0] ny, logic [6:0] nz);
    write_reg(pcne_pkg::REG_SIDE_X, 32'(sx));
    write_reg(pcne_pkg::REG_SIDE_Y, 32'(sy));
    write_reg(pcne_pkg::REG_SIDE_Z, 32'(sz));
    write_reg(pcne_pkg::REG_CELL_SIZE, 32'(cs));
    write_reg(pcne_pkg::REG_CELLS_X, 32'(nx));
    write_reg(pcne_pkg::REG_CELLS_Y, 32'(ny));
    write_reg(pcne_pkg::REG_CELLS_Z, 32'(nz));
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 2)) - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_pos(32'h0001_8000, 32'hffff_0000, 32'h0);
    drain();
  endtask

  task automatic test_directed();
    configure(31'd8 << 16, 31'd8 << 16, 31'd8 << 16, 31'd1 << 16, 7'd8, 7'd8, 7'd8);
    send_pos(32'h0, 32'h0, 32'h0);
    send_pos(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_pos(32'h0007_ffff, 32'h0003_0000, 32'hfff8_0000);
    send_pos(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_pos(32'h5555_5555, 32'haaaa_aaaa, 32'h0);
    drain();
    configure(31'h7fff_ffff, 31'd0, 31'd3 << 16, 31'd0, 7'd0, 7'd2, 7'd127);
    send_pos(32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff);
    drain();
    configure(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'd1, 7'd64, 7'd64, 7'd64);
    send_pos(32'h7fff_ffff, 32'h7ffe_ffff, 32'h8000_0000);
    send_pos(32'h0, 32'h0000_003f, 32'hffff_ffc0);
    drain();
    configure(31'd5 << 16, 31'd1, 31'd4 << 16, 31'd1 << 16, 7'd5, 7'd1, 7'd3);
    send_pos(32'hffff_0000, 32'h1, 32'h0004_0000);
    send_pos(32'h0004_ffff, 32'hffff_ffff, 32'hfffc_0001);
    drain();
    configure(31'd3 << 16, 31'd7 << 16, 31'd2 << 16, 31'd1 << 16, 7'd3, 7'd100, 7'd2);
    send_pos(32'h0002_8000, 32'h0006_0000, 32'h0001_0000);
    drain();
  endtask

  task automatic test_random(int items);
    for (int n = 0; n < items; n++) begin
      if (n % 20 == 0) begin
        drain();
        configure($urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 40)) << 16,
                  $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 40)) << 16,
                  $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 40)) << 16,
                  $urandom_range(0, 5) == 0 ? 31'($urandom) : 31'($urandom_range(1, 131072)),
                  7'($urandom_range(0, 70)), 7'($urandom_range(0, 70)),
                  7'($urandom_range(0, 70)));
      end
      send_pos(rand_pos(), rand_pos(), rand_pos());
    end
    drain();
  endtask

  task automatic test_backpressure();
    configure(31'd16 << 16, 31'd16 << 16, 31'd16 << 16, 31'd1 << 16, 7'd16, 7'd16, 7'd16);
    hold_sink = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end
      begin
        send_pos($urandom, $urandom, $urandom);
        in_tvalid <= 1'b0;
        repeat (110) @(negedge clk);
        for (int n = 0; n < 5; n++) send_pos($urandom, $urandom, $urandom);
      end
    join
    drain();
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    for (int n = 0; n < 10; n++) send_pos(rand_pos(), rand_pos(), rand_pos());
    drain();
  endtask

  always @(posedge clk) begin
    cell_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cells_due.size() == 0) begin
        report("unexpected result", 32'(out_tdata[17:0]), 32'd0);
      end else begin
        want = cells_due.pop_front();
        if (out_tdata[17:0] !== want.home)
          report("home_cell", 32'(out_tdata[17:0]), 32'(want.home));
        if (out_tdata[35:18] !== want.nbr)
          report("neighbor_cell", 32'(out_tdata[35:18]), 32'(want.nbr));
        if (out_tdata[39:36] !== 4'b0) report("pad", 32'(out_tdata[39:36]), 32'd0);
        if (out_tlast !== want.last) report("last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_sink) begin
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (!sink_idle && $urandom_range(5) == 0) begin
      sink_idle = 1'b1;
      out_tready <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end else begin
      sink_idle = 1'b0;
      out_tready <= 1'b1;
    end
  end

  initial begin
    box_x = 31'd65536;
    box_y = 31'd65536;
    box_z = 31'd65536;
    edge_len = 31'd65536;
    cnt_x = 7'd1;
    cnt_y = 7'd1;
    cnt_z = 7'd1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random(82);
    test_no_idle();
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
